FILE: rtl/spwlt_pkg.sv
// ----------------------------------------------------------------------------
// spwlt_pkg
// Shared types and constants of the sorted piecewise linear valve table.
// ----------------------------------------------------------------------------
`default_nettype none

package spwlt_pkg;

  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned ValW = 15;
  localparam logic [ValW-1:0] FullScale = 15'd25600;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_REJECTED = 2'd1,
    STS_PASS     = 2'd2
  } status_e;

  typedef struct packed {
    logic [ValW-1:0] pos;
    logic [ValW-1:0] flow;
  } point_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_piecewise_linear_table_top.sv
// ----------------------------------------------------------------------------
// sorted_piecewise_linear_table_top
// Valve characteristic table: stages points, sorts them into a table and
// interpolates the flow for a stem position.
// ----------------------------------------------------------------------------
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, command_i, ...    | upstream -> block
//   out     | out_valid_o, out_stall_i, status_o, ...   | block -> downstream
//
// A load, a rejected build and a lookup without a table go straight to the output.
// A lookup runs a binary search of table probes, reads the two operand points,
// multiplies, divides in the bit-serial divider, clamps and outputs the flow.
// A build copies the staged points into the table, sorts them and fixes flows,
// all bound by the single read port of the table memory.
// Reset clears the state, the table size and the output valid flag only; stalls
// on the output hold the result register while the next item may already be
// accepted.
`default_nettype none

module sorted_piecewise_linear_table_top import spwlt_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire  [1:0]       command_i,
  input  wire  [5:0]       point_index_i,
  input  wire  [ValW-1:0]  point_position_i,
  input  wire  [ValW-1:0]  point_flow_i,
  input  wire  [6:0]       point_count_i,
  input  wire  [ValW-1:0]  stem_position_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [1:0]       status_o,
  output logic [ValW-1:0]  flow_value_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned NumW = 30;

  typedef enum logic [20:0] {
    ST_IDLE   = 21'd1 << 0,
    ST_OUT    = 21'd1 << 1,
    ST_CP_RD  = 21'd1 << 2,
    ST_CP_WR  = 21'd1 << 3,
    ST_SI_RD  = 21'd1 << 4,
    ST_SI_LD  = 21'd1 << 5,
    ST_SJ_RD  = 21'd1 << 6,
    ST_SJ_CMP = 21'd1 << 7,
    ST_SI_WR  = 21'd1 << 8,
    ST_FX_RD0 = 21'd1 << 9,
    ST_FX_LD0 = 21'd1 << 10,
    ST_FX_RD  = 21'd1 << 11,
    ST_FX_CMP = 21'd1 << 12,
    ST_LK_RD  = 21'd1 << 13,
    ST_LK_CMP = 21'd1 << 14,
    ST_LK_RLO = 21'd1 << 15,
    ST_LK_RHI = 21'd1 << 16,
    ST_LK_GET = 21'd1 << 17,
    ST_LK_MUL = 21'd1 << 18,
    ST_LK_DIV = 21'd1 << 19,
    ST_LK_FIN = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] tp_q, tp_d;
  logic out_valid_q, out_valid_d;

  logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  point_t cur_q, cur_d, prev_q, prev_d, p1_q, p1_d, p2_q, p2_d;
  logic [ValW-1:0] s_q, s_d, den_q, den_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [ValW-1:0] rem_q, rem_d;
  logic [4:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic [1:0] res_status_q, res_status_d, status_q, status_d;
  logic [ValW-1:0] res_flow_q, res_flow_d, flow_q, flow_d;

  point_t stg_mem [MAX_POINTS];
  point_t tbl_mem [MAX_POINTS];
  point_t stg_rdata_q, tbl_rdata_q, tbl_wdata;
  logic stg_we, tbl_we;
  logic [AW-1:0] stg_waddr, tbl_raddr, tbl_waddr;

  logic accept;
  logic [AW:0] lo_next, hi_next;
  logic signed [16:0] dx, dy;
  logic signed [33:0] prod;
  logic [NumW-1:0] prod_mag;
  logic [ValW:0] rem_sh;
  logic rem_ge;
  logic signed [31:0] fsum;
  point_t fx_e;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign flow_value_o = flow_q;

  assign stg_we    = accept && (command_i == CMD_LOAD) && (int'(point_index_i) < MAX_POINTS);
  assign stg_waddr = AW'(point_index_i);

  assign dx       = $signed({2'b00, s_q}) - $signed({2'b00, p1_q.pos});
  assign dy       = $signed({2'b00, p2_q.flow}) - $signed({2'b00, p1_q.flow});
  assign prod     = dx * dy;
  assign prod_mag = prod[33] ? NumW'(-prod) : NumW'(prod);
  assign rem_sh   = {rem_q, quo_q[NumW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, den_q});
  assign fsum     = neg_q ? ($signed({17'd0, p1_q.flow}) - $signed({2'b00, quo_q}))
                          : ($signed({17'd0, p1_q.flow}) + $signed({2'b00, quo_q}));

  always_comb begin
    fx_e = tbl_rdata_q;
    if ((tbl_rdata_q.flow < prev_q.flow) && (tbl_rdata_q.pos > prev_q.pos)) begin
      fx_e.flow = prev_q.flow;
    end
  end

  always_comb begin
    state_d      = state_q;
    tp_d         = tp_q;
    out_valid_d  = out_valid_q;
    n_d          = n_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    s_d          = s_q;
    den_d        = den_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    res_status_d = res_status_q;
    res_flow_d   = res_flow_q;
    status_d     = status_q;
    flow_d       = flow_q;
    tbl_raddr    = AW'(i_q);
    tbl_we       = 1'b0;
    tbl_waddr    = AW'(i_q);
    tbl_wdata    = cur_q;
    lo_next      = {1'b0, lo_q};
    hi_next      = {1'b0, hi_q};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_status_d = STS_OK;
          res_flow_d   = '0;
          state_d      = ST_OUT;
          case (command_i)
            CMD_BUILD: begin
              if ((point_count_i < 7'd2) || (int'(point_count_i) > MAX_POINTS)) begin
                res_status_d = STS_REJECTED;
              end else begin
                n_d     = CW'(point_count_i);
                k_d     = '0;
                state_d = ST_CP_RD;
              end
            end
            CMD_LOOKUP: begin
              if (tp_q < CW'(2)) begin
                res_status_d = STS_PASS;
                res_flow_d   = stem_position_i;
              end else begin
                s_d  = (stem_position_i > FullScale) ? FullScale : stem_position_i;
                lo_d = '0;
                hi_d = AW'(tp_q - 1'b1);
                mid_d = AW'((AW + 1)'(tp_q - 1'b1) >> 1);
                state_d = ((AW + 1)'(1) < (AW + 1)'(tp_q - 1'b1)) ? ST_LK_RD : ST_LK_RLO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          flow_d      = res_flow_q;
          state_d     = ST_IDLE;
        end
      end
      ST_CP_RD: begin
        state_d = ST_CP_WR;
      end
      ST_CP_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = AW'(k_q);
        tbl_wdata = stg_rdata_q;
        k_d       = k_q + 1'b1;
        if (CW'(k_q + 1'b1) == n_q) begin
          i_d     = '0;
          state_d = ST_SI_RD;
        end else begin
          state_d = ST_CP_RD;
        end
      end
      ST_SI_RD: begin
        tbl_raddr = AW'(i_q);
        state_d   = ST_SI_LD;
      end
      ST_SI_LD: begin
        cur_d   = tbl_rdata_q;
        j_d     = i_q + 1'b1;
        state_d = ST_SJ_RD;
      end
      ST_SJ_RD: begin
        tbl_raddr = AW'(j_q);
        state_d   = ST_SJ_CMP;
      end
      ST_SJ_CMP: begin
        if (tbl_rdata_q.pos < cur_q.pos) begin
          tbl_we    = 1'b1;
          tbl_waddr = AW'(j_q);
          tbl_wdata = cur_q;
          cur_d     = tbl_rdata_q;
        end
        j_d     = j_q + 1'b1;
        state_d = (CW'(j_q + 1'b1) == n_q) ? ST_SI_WR : ST_SJ_RD;
      end
      ST_SI_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = AW'(i_q);
        tbl_wdata = cur_q;
        i_d       = i_q + 1'b1;
        state_d   = ((CW + 1)'(i_q) + (CW + 1)'(2) == (CW + 1)'(n_q)) ? ST_FX_RD0 : ST_SI_RD;
      end
      ST_FX_RD0: begin
        tbl_raddr = '0;
        state_d   = ST_FX_LD0;
      end
      ST_FX_LD0: begin
        prev_d  = tbl_rdata_q;
        k_d     = CW'(1);
        state_d = ST_FX_RD;
      end
      ST_FX_RD: begin
        tbl_raddr = AW'(k_q);
        state_d   = ST_FX_CMP;
      end
      ST_FX_CMP: begin
        tbl_we    = 1'b1;
        tbl_waddr = AW'(k_q);
        tbl_wdata = fx_e;
        prev_d    = fx_e;
        k_d       = k_q + 1'b1;
        if (CW'(k_q + 1'b1) == n_q) begin
          tp_d    = n_q;
          state_d = ST_OUT;
        end else begin
          state_d = ST_FX_RD;
        end
      end
      ST_LK_RD: begin
        tbl_raddr = mid_q;
        state_d   = ST_LK_CMP;
      end
      ST_LK_CMP: begin
        if (tbl_rdata_q.pos <= s_q) begin
          lo_next = {1'b0, mid_q};
        end else begin
          hi_next = {1'b0, mid_q};
        end
        lo_d    = AW'(lo_next);
        hi_d    = AW'(hi_next);
        mid_d   = AW'((lo_next + hi_next) >> 1);
        state_d = ((lo_next + 1'b1) < hi_next) ? ST_LK_RD : ST_LK_RLO;
      end
      ST_LK_RLO: begin
        tbl_raddr = lo_q;
        state_d   = ST_LK_RHI;
      end
      ST_LK_RHI: begin
        tbl_raddr = hi_q;
        p1_d      = tbl_rdata_q;
        state_d   = ST_LK_GET;
      end
      ST_LK_GET: begin
        p2_d = tbl_rdata_q;
        if (tbl_rdata_q.pos == p1_q.pos) begin
          res_flow_d = p1_q.flow;
          state_d    = ST_OUT;
        end else begin
          state_d = ST_LK_MUL;
        end
      end
      ST_LK_MUL: begin
        neg_d   = prod[33];
        quo_d   = prod_mag;
        rem_d   = '0;
        den_d   = p2_q.pos - p1_q.pos;
        cnt_d   = '0;
        state_d = ST_LK_DIV;
      end
      ST_LK_DIV: begin
        rem_d = rem_ge ? ValW'(rem_sh - {1'b0, den_q}) : rem_sh[ValW-1:0];
        quo_d = {quo_q[NumW-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(NumW - 1)) begin
          state_d = ST_LK_FIN;
        end
      end
      ST_LK_FIN: begin
        if (fsum < 0) begin
          res_flow_d = '0;
        end else if (fsum > $signed({17'd0, FullScale})) begin
          res_flow_d = FullScale;
        end else begin
          res_flow_d = fsum[ValW-1:0];
        end
        state_d = ST_OUT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tp_q        <= tp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    i_q          <= i_d;
    j_q          <= j_d;
    k_q          <= k_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    p1_q         <= p1_d;
    p2_q         <= p2_d;
    s_q          <= s_d;
    den_q        <= den_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    neg_q        <= neg_d;
    res_status_q <= res_status_d;
    res_flow_q   <= res_flow_d;
    status_q     <= status_d;
    flow_q       <= flow_d;
  end

  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= {point_position_i, point_flow_i};
    end
    stg_rdata_q <= stg_mem[AW'(k_q)];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

endmodule

`default_nettype wire
